>>> hdl/ntcbt_pkg.sv
// ----------------------------------------------------------------------------
// NTC beta converter package
// Shared constants, widths, codes and types of the temperature converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ntcbt_pkg;

  // Samples averaged for one result.
  localparam int SAMPLES   = 16;
  localparam int SAMPLE_W  = 12;
  localparam int SUM_W     = SAMPLE_W + $clog2(SAMPLES);
  localparam int CNT_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int MEAN_W    = 16;

  // Arithmetic widths of the back end.
  localparam int PROD_W    = 41;  // ohms times sixteenth millivolts
  localparam int LOG_W     = 26;  // log2 in Q20, integer part up to 40
  localparam int DVD_W     = 61;  // shared divider dividend
  localparam int DVS_W     = 45;  // shared divider divisor

  localparam int RAIL_MARGIN_X16 = 400;
  localparam int ZERO_C_CENTI_K  = 27315;
  localparam int LN2_Q30         = 744261118;
  localparam int T_MIN_CENTI     = -1000;
  localparam int T_MAX_CENTI     = 20000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SUPPLY  = 3'd0;
  localparam logic [2:0] REG_SERIES  = 3'd1;
  localparam logic [2:0] REG_HIGH    = 3'd2;
  localparam logic [2:0] REG_NOMINAL = 3'd3;
  localparam logic [2:0] REG_BETA    = 3'd4;
  localparam logic [2:0] REG_REFTEMP = 3'd5;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RAIL = 2'd1,
    ST_RES  = 2'd2,
    ST_TEMP = 2'd3
  } status_e;

  typedef struct packed {
    logic        [12:0] supply_mv;
    logic        [23:0] series_ohms;
    logic               ntc_high_side;
    logic        [23:0] nominal_ohms;
    logic        [16:0] beta_kelvin;
    logic signed [14:0] ref_temp_centi_c;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] temp_centi_c;
    status_e            status;
    logic        [15:0] mean_mv_x16;
    logic        [31:0] resistance_ohms;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ntcbt_if.sv
// ----------------------------------------------------------------------------
// NTC beta converter channels
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ntcbt_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink (input valid, input sample_mv, output ready);
endinterface

interface ntcbt_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temp_centi_c;
  logic        [1:0]  status;
  logic        [15:0] mean_mv_x16;
  logic        [31:0] resistance_ohms;

  modport source (output valid, output temp_centi_c, output status,
                  output mean_mv_x16, output resistance_ohms, input ready);
  modport sink (input valid, input temp_centi_c, input status,
                input mean_mv_x16, input resistance_ohms, output ready);
endinterface

`default_nettype wire

>>> hdl/ntc_beta_temperature_converter.sv
// ----------------------------------------------------------------------------
// NTC beta temperature converter
// Averages divider samples and converts them to a thermistor temperature.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Content
//   in_if     in         valid/ready     sample_mv, one node reading in mV
//   out_if    out        valid/ready     temp, status, mean, resistance
//   APB       in         psel/penable    six calibration registers at 4*i
//
// The front end takes one sample per cycle while its queue has room, and
// queues a mean every SAMPLES samples in a two-entry queue. The back end
// takes one mean at a time, using the bit-serial divider twice and the two
// logarithms (up to 41 normalize steps and 20 squarings each).
// Reset clears the sample sum, queue, sequencer and output valid; the
// registers return to their defaults. A stalled output holds the back end
// in its final state while the front end keeps filling the queue.
`default_nettype none

module ntc_beta_temperature_converter import ntcbt_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  ntcbt_sample_if.sink      in_if,
  ntcbt_result_if.source    out_if,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire [4:0]         paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Zero writes to the nominal resistance or beta are dropped, since the
  // equation needs both to be positive.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.supply_mv        <= 13'd3300;
      cfg_q.series_ohms      <= 24'd10000;
      cfg_q.ntc_high_side    <= 1'b0;
      cfg_q.nominal_ohms     <= 24'd10000;
      cfg_q.beta_kelvin      <= 17'd3950;
      cfg_q.ref_temp_centi_c <= 15'sd2500;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SUPPLY:  cfg_q.supply_mv     <= pwdata[12:0];
        REG_SERIES:  cfg_q.series_ohms   <= pwdata[23:0];
        REG_HIGH:    cfg_q.ntc_high_side <= pwdata[0];
        REG_NOMINAL: if (pwdata[23:0] != '0) cfg_q.nominal_ohms <= pwdata[23:0];
        REG_BETA:    if (pwdata[16:0] != '0) cfg_q.beta_kelvin <= pwdata[16:0];
        REG_REFTEMP: cfg_q.ref_temp_centi_c <= $signed(pwdata[14:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SUPPLY:  prdata = 32'(cfg_q.supply_mv);
      REG_SERIES:  prdata = 32'(cfg_q.series_ohms);
      REG_HIGH:    prdata = 32'(cfg_q.ntc_high_side);
      REG_NOMINAL: prdata = 32'(cfg_q.nominal_ohms);
      REG_BETA:    prdata = 32'(cfg_q.beta_kelvin);
      REG_REFTEMP: prdata = 32'(cfg_q.ref_temp_centi_c);
      default:     prdata = '0;
    endcase
  end

  // Means travel from the front end to the back end through the queue.
  logic [MEAN_W-1:0] mean;
  logic              mean_valid, mean_ready;

  ntcbt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .mean_o       (mean),
    .mean_valid_o (mean_valid),
    .mean_ready_i (mean_ready)
  );

  ntcbt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .mean_i       (mean),
    .mean_valid_i (mean_valid),
    .mean_ready_o (mean_ready),
    .out_if       (out_if)
  );

endmodule

`default_nettype wire

>>> hdl/ntcbt_front.sv
// ----------------------------------------------------------------------------
// NTC beta converter front end
// Sums samples, forms the mean of each group and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcbt_front import ntcbt_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  ntcbt_sample_if.sink       in_if,
  output logic [MEAN_W-1:0]  mean_o,
  output logic               mean_valid_o,
  input  wire                mean_ready_i
);

  logic [SUM_W-1:0]  sum_q, sum_d, sum_next;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [MEAN_W-1:0] mean_new;
  logic              accept, last, push, pop;

  // Two-entry queue of means.
  logic [MEAN_W-1:0] queue_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        fill_q;

  assign in_if.ready = (fill_q != 2'd2);
  assign accept      = in_if.valid & in_if.ready;
  assign sum_next    = sum_q + SUM_W'(in_if.sample_mv);
  assign last        = (cnt_q == CNT_W'(SAMPLES - 1));
  assign mean_new    = MEAN_W'({sum_next, 4'b0000} / SAMPLES);
  assign push        = accept & last;
  assign pop         = mean_valid_o & mean_ready_i;

  assign mean_valid_o = (fill_q != 2'd0);
  assign mean_o       = queue_q[rd_ptr_q];

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (last) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_next;
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= mean_new;
  end

endmodule

`default_nettype wire

>>> hdl/ntcbt_div.sv
// ----------------------------------------------------------------------------
// NTC beta converter divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcbt_div import ntcbt_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire [DVD_W-1:0]   dividend_i,
  input  wire [DVS_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [DVD_W-1:0]  quotient_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0]  dvs_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic [DVS_W:0]    rem_sh;
  logic [DVS_W+1:0]  diff;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign fits   = ~diff[DVS_W+1];
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> hdl/ntcbt_log.sv
// ----------------------------------------------------------------------------
// NTC beta converter base-2 logarithm
// Finds the leading one by shifting, then takes 20 fraction bits by squaring.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcbt_log import ntcbt_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start_i,
  input  wire [PROD_W-1:0]  x_i,
  output logic              done_o,
  output logic [LOG_W-1:0]  log_o
);

  typedef enum logic [2:0] {
    LG_IDLE = 3'b001,
    LG_NORM = 3'b010,
    LG_SQR  = 3'b100
  } lg_state_e;

  lg_state_e     state_q;
  logic [PROD_W-1:0] x_q;
  logic [5:0]    exp_q;
  logic [30:0]   y_q;
  logic [19:0]   frac_q;
  logic [4:0]    iter_q;
  logic [61:0]   sq_full;
  logic [31:0]   sq;

  // The mantissa sits in Q30, in [1,2).
  assign sq_full = y_q * y_q;
  assign sq      = sq_full[61:30];
  assign log_o   = {exp_q, frac_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LG_IDLE;
      done_o  <= 1'b0;
      iter_q  <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        LG_IDLE: begin
          if (start_i) state_q <= LG_NORM;
        end
        LG_NORM: begin
          if (x_q[PROD_W-1]) begin
            state_q <= LG_SQR;
            iter_q  <= '0;
          end
        end
        LG_SQR: begin
          iter_q <= iter_q + 5'd1;
          if (iter_q == 5'd19) begin
            state_q <= LG_IDLE;
            done_o  <= 1'b1;
          end
        end
        default: state_q <= LG_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == LG_IDLE && start_i) begin
      x_q    <= x_i;
      exp_q  <= 6'(PROD_W - 1);
      frac_q <= '0;
    end else if (state_q == LG_NORM) begin
      if (x_q[PROD_W-1]) begin
        y_q <= x_q[PROD_W-1 -: 31];
      end else begin
        x_q   <= {x_q[PROD_W-2:0], 1'b0};
        exp_q <= exp_q - 6'd1;
      end
    end else if (state_q == LG_SQR) begin
      frac_q <= {frac_q[18:0], sq[31]};
      y_q    <= sq[31] ? sq[31:1] : sq[30:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/ntcbt_back.sv
// ----------------------------------------------------------------------------
// NTC beta converter back end
// Sequencer from a mean to resistance, logarithm and temperature.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcbt_back import ntcbt_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  cfg_t              cfg_i,
  input  wire [MEAN_W-1:0]  mean_i,
  input  wire               mean_valid_i,
  output logic              mean_ready_o,
  ntcbt_result_if.source    out_if
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_PREP  = 12'b0000_0000_0010,
    S_RDIV  = 12'b0000_0000_0100,
    S_RWAIT = 12'b0000_0000_1000,
    S_LOGN  = 12'b0000_0001_0000,
    S_LOGD  = 12'b0000_0010_0000,
    S_LNMUL = 12'b0000_0100_0000,
    S_DEN2  = 12'b0000_1000_0000,
    S_SUM   = 12'b0001_0000_0000,
    S_TDIV  = 12'b0010_0000_0000,
    S_TWAIT = 12'b0100_0000_0000,
    S_DONE  = 12'b1000_0000_0000
  } bk_state_e;

  bk_state_e state_q;

  logic [MEAN_W-1:0]  m_q;
  logic [PROD_W-1:0]  rnum_q, rden_q;
  logic [16:0]        den_q;
  logic [LOG_W-1:0]   lnum_q;
  logic signed [25:0] n_q;
  logic [23:0]        pb_q;
  logic [15:0]        k0_q;
  logic signed [42:0] kn_q;
  logic [39:0]        tnum_q;
  logic signed [45:0] den2_q;
  result_t            res_q;
  logic               out_valid_q;

  // Preparation of the divider node values.
  logic [16:0] s_x16, d_val, num_val, den_val;
  logic        rail;
  assign s_x16 = {cfg_i.supply_mv, 4'b0000};
  assign rail  = (m_q < 16'(RAIL_MARGIN_X16)) ||
                 ({1'b0, m_q} + 17'(RAIL_MARGIN_X16) > s_x16);
  assign d_val   = s_x16 - {1'b0, m_q};
  assign num_val = cfg_i.ntc_high_side ? d_val : {1'b0, m_q};
  assign den_val = cfg_i.ntc_high_side ? {1'b0, m_q} : d_val;

  // Shared divider and logarithm units.
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;
  logic             log_start, log_done;
  logic [PROD_W-1:0] log_x;
  logic [LOG_W-1:0] log_res;

  assign div_start = (state_q == S_RDIV) ||
                     (state_q == S_TDIV && !den2_q[45] && den2_q != '0);
  assign div_dvd   = (state_q == S_RDIV) ? DVD_W'(rnum_q)
                   : ({1'b0, tnum_q, 20'b0} + DVD_W'(den2_q[45:1]));
  assign div_dvs   = (state_q == S_RDIV) ? DVS_W'(den_q) : den2_q[DVS_W-1:0];

  assign log_start = (state_q == S_RWAIT && div_done && rnum_q != '0 && div_q != '0) ||
                     (state_q == S_LOGN && log_done);
  assign log_x     = (state_q == S_RWAIT) ? rnum_q : rden_q;

  ntcbt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  ntcbt_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (log_x),
    .done_o  (log_done),
    .log_o   (log_res)
  );

  // ln(R/R0) in Q20, truncated toward zero.
  logic signed [26:0] l_diff;
  logic [25:0]        l_abs;
  logic [55:0]        ln_prod;
  logic [25:0]        n_mag;
  assign l_diff  = $signed({1'b0, lnum_q}) - $signed({1'b0, log_res});
  assign l_abs   = l_diff[26] ? 26'(-l_diff) : l_diff[25:0];
  assign ln_prod = l_abs * 30'(LN2_Q30);
  assign n_mag   = ln_prod[55:30];

  // Temperature range check on the centi-kelvin quotient.
  logic t_ok;
  assign t_ok = (div_q >= DVD_W'(ZERO_C_CENTI_K + T_MIN_CENTI)) &&
                (div_q <= DVD_W'(ZERO_C_CENTI_K + T_MAX_CENTI));

  logic [16:0] k0_full;
  assign k0_full = 17'($signed(cfg_i.ref_temp_centi_c)) + 17'(ZERO_C_CENTI_K);

  logic load_out;
  assign load_out     = (state_q == S_DONE) && (!out_valid_q || out_if.ready);
  assign mean_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_if.ready) out_valid_q <= 1'b0;
      if (load_out) out_valid_q <= 1'b1;
      unique case (state_q)
        S_IDLE:  if (mean_valid_i) state_q <= S_PREP;
        S_PREP:  state_q <= rail ? S_DONE : S_RDIV;
        S_RDIV:  state_q <= S_RWAIT;
        S_RWAIT: if (div_done) state_q <= log_start ? S_LOGN : S_DONE;
        S_LOGN:  if (log_done) state_q <= S_LOGD;
        S_LOGD:  if (log_done) state_q <= S_LNMUL;
        S_LNMUL: state_q <= S_DEN2;
        S_DEN2:  state_q <= S_SUM;
        S_SUM:   state_q <= S_TDIV;
        S_TDIV:  state_q <= div_start ? S_TWAIT : S_DONE;
        S_TWAIT: if (div_done) state_q <= S_DONE;
        S_DONE:  if (load_out) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (mean_valid_i) begin
          m_q                   <= mean_i;
          res_q.mean_mv_x16     <= mean_i;
          res_q.temp_centi_c    <= '0;
          res_q.resistance_ohms <= '0;
          res_q.status          <= ST_OK;
        end
      end
      S_PREP: begin
        if (rail) res_q.status <= ST_RAIL;
        rnum_q <= cfg_i.series_ohms * num_val;
        rden_q <= cfg_i.nominal_ohms * den_val;
        den_q  <= den_val;
      end
      S_RWAIT: begin
        if (div_done) begin
          res_q.resistance_ohms <= (|div_q[DVD_W-1:32]) ? '1 : div_q[31:0];
          if (!log_start) res_q.status <= ST_RES;
        end
      end
      S_LOGN: begin
        if (log_done) lnum_q <= log_res;
      end
      S_LOGD: begin
        if (log_done) n_q <= l_diff[26] ? -$signed(n_mag) : $signed(n_mag);
      end
      S_LNMUL: begin
        pb_q <= 24'(cfg_i.beta_kelvin) * 24'd100;
        k0_q <= k0_full[15:0];
      end
      S_DEN2: begin
        kn_q   <= $signed({1'b0, k0_q}) * n_q;
        tnum_q <= pb_q * k0_q;
      end
      S_SUM: begin
        den2_q <= $signed({2'b00, pb_q, 20'b0}) + 46'(kn_q);
      end
      S_TDIV: begin
        if (!div_start) res_q.status <= ST_TEMP;
      end
      S_TWAIT: begin
        if (div_done) begin
          if (t_ok) begin
            res_q.temp_centi_c <= 16'(17'(div_q[15:0]) - 17'(ZERO_C_CENTI_K));
          end else begin
            res_q.status <= ST_TEMP;
          end
        end
      end
      S_RDIV, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register parts the back end from the result consumer.
  result_t out_q;
  always_ff @(posedge clk_i) begin
    if (load_out) out_q <= res_q;
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.temp_centi_c    = out_q.temp_centi_c;
  assign out_if.status          = out_q.status;
  assign out_if.mean_mv_x16     = out_q.mean_mv_x16;
  assign out_if.resistance_ohms = out_q.resistance_ohms;

endmodule

`default_nettype wire

>>> tb/sv/ntcbt_checker.sv
// ----------------------------------------------------------------------------
// NTC beta converter checker
// Watches the sample, result and register channels, predicts each result and
// compares it field by field with what the converter delivers.
// ----------------------------------------------------------------------------
`default_nettype none

module ntcbt_checker import ntcbt_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  ntcbt_sample_if     smp_mon,
  ntcbt_result_if     res_mon,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  input  wire         pready,
  output int          fail_cnt,
  output int          pending_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t                cal;
  longint unsigned     sample_sum;
  int                  sample_cnt;
  result_t             expected_q[$];

  // Base-2 logarithm in Q20 by repeated squaring of the normalized mantissa.
  function automatic longint log2_q20(input longint unsigned x);
    int              p;
    longint unsigned y;
    longint          frac;
    p = 63;
    frac = 0;
    while (p > 0 && x[p] == 1'b0) p--;
    if (p >= 30) y = x >> (p - 30);
    else y = x << (30 - p);
    for (int i = 0; i < 20; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= (64'd2 << 30)) begin
        frac = frac | 1;
        y = y >> 1;
      end
    end
    return (longint'(p) << 20) + frac;
  endfunction

  function automatic result_t convert_mean(input longint unsigned sum, input cfg_t c);
    result_t         res;
    longint          m, s, num, den, n, k0, den2, t, temp;
    longint          beta;
    longint unsigned rnum, rden, r;
    res = '0;
    temp = 0;
    r = 0;
    m = longint'((sum * 16) / SAMPLES);
    s = longint'(c.supply_mv) * 16;
    beta = longint'(c.beta_kelvin);
    res.status = ST_OK;
    if (m < RAIL_MARGIN_X16 || m > s - RAIL_MARGIN_X16) begin
      res.status = ST_RAIL;
    end else begin
      if (c.ntc_high_side) begin
        num = s - m;
        den = m;
      end else begin
        num = m;
        den = s - m;
      end
      rnum = longint'(c.series_ohms) * num;
      rden = longint'(c.nominal_ohms) * den;
      r = rnum / longint'(den);
      if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
      if (rnum == 0 || r == 0) begin
        res.status = ST_RES;
      end else begin
        n = ((log2_q20(rnum) - log2_q20(rden)) * longint'(LN2_Q30)) / (longint'(1) << 30);
        k0 = longint'(c.ref_temp_centi_c) + ZERO_C_CENTI_K;
        den2 = 100 * beta * (longint'(1) << 20) + k0 * n;
        if (den2 <= 0) begin
          res.status = ST_TEMP;
        end else begin
          t = (100 * beta * k0 * (longint'(1) << 20) + den2 / 2) / den2;
          temp = t - ZERO_C_CENTI_K;
          if (temp < T_MIN_CENTI || temp > T_MAX_CENTI) begin
            res.status = ST_TEMP;
            temp = 0;
          end
        end
      end
    end
    res.temp_centi_c = temp[15:0];
    res.mean_mv_x16 = m[15:0];
    res.resistance_ohms = r[31:0];
    return res;
  endfunction

  assign pending_cnt = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    logic [2:0] idx;
    if (!rst_ni) begin
      cal.supply_mv <= 13'd3300;
      cal.series_ohms <= 24'd10000;
      cal.ntc_high_side <= 1'b0;
      cal.nominal_ohms <= 24'd10000;
      cal.beta_kelvin <= 17'd3950;
      cal.ref_temp_centi_c <= 15'sd2500;
      sample_sum <= 0;
      sample_cnt <= 0;
      fail_cnt <= 0;
      expected_q.delete();
    end else begin
      // Register writes land at the access cycle; zero nominal or beta writes are ignored.
      if (psel && penable && pwrite && pready) begin
        idx = paddr[4:2];
        case (idx)
          REG_SUPPLY:  cal.supply_mv <= pwdata[12:0];
          REG_SERIES:  cal.series_ohms <= pwdata[23:0];
          REG_HIGH:    cal.ntc_high_side <= pwdata[0];
          REG_NOMINAL: if (pwdata[23:0] != 0) cal.nominal_ohms <= pwdata[23:0];
          REG_BETA:    if (pwdata[16:0] != 0) cal.beta_kelvin <= pwdata[16:0];
          REG_REFTEMP: cal.ref_temp_centi_c <= pwdata[14:0];
          default: ;
        endcase
      end
      if (smp_mon.valid && smp_mon.ready) begin
        if (sample_cnt + 1 >= SAMPLES) begin
          expected_q.push_back(convert_mean(sample_sum + smp_mon.sample_mv, cal));
          sample_sum <= 0;
          sample_cnt <= 0;
        end else begin
          sample_sum <= sample_sum + smp_mon.sample_mv;
          sample_cnt <= sample_cnt + 1;
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (expected_q.size() == 0) begin
          if (fail_cnt < 10) $display("Unexpected result item: temp %0d status %0d",
                                      res_mon.temp_centi_c, res_mon.status);
          fail_cnt <= fail_cnt + 1;
        end else begin
          want = expected_q.pop_front();
          if (res_mon.temp_centi_c !== want.temp_centi_c || res_mon.status !== want.status ||
              res_mon.mean_mv_x16 !== want.mean_mv_x16 ||
              res_mon.resistance_ohms !== want.resistance_ohms) begin
            if (fail_cnt < 10) begin
              $display("Result mismatch: expected temp %0d status %0d mean %0d ohms %0d",
                       want.temp_centi_c, want.status, want.mean_mv_x16,
                       want.resistance_ohms);
              $display("                 got      temp %0d status %0d mean %0d ohms %0d",
                       res_mon.temp_centi_c, res_mon.status, res_mon.mean_mv_x16,
                       res_mon.resistance_ohms);
            end
            fail_cnt <= fail_cnt + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

>>> tb/sv/ntc_beta_temperature_converter_tb.sv
// ----------------------------------------------------------------------------
// NTC beta converter testbench
// Drives groups of divider samples under many calibration settings, with
// random gaps and output stalls, and lets the checker judge every result.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_beta_temperature_converter_tb;
  import ntcbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // The front end queues two means ahead of the back end, so this quiet spell
  // leaves the back end idle before a calibration write.
  localparam int SETTLE_CYCLES = 800;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_cnt;
  int          pending_cnt;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          gaps_on = 1'b1;

  ntcbt_sample_if smp_if ();
  ntcbt_result_if res_if ();

  always #10 clk_i = ~clk_i;

  ntc_beta_temperature_converter DUT (
    .clk_i, .rst_ni, .in_if(smp_if), .out_if(res_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ntcbt_checker u_checker (
    .clk_i, .rst_ni, .smp_mon(smp_if), .res_mon(res_if),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_cnt, .pending_cnt
  );

  // The result side stalls in short bursts while gaps are enabled.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (!gaps_on) begin
      res_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      res_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      res_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk_i) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ntc_beta_temperature_converter_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Register write: setup, then access with the write at its end, after which
  // the port returns to idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every expected result has arrived and the back end is quiet.
  task automatic wait_drained();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [11:0] value);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      smp_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    smp_if.valid <= 1'b1;
    smp_if.sample_mv <= value;
    do @(posedge clk_i); while (!smp_if.ready);
  endtask

  // One averaging group around a center voltage with a little noise.
  task automatic send_group(input int center, input int spread);
    int v;
    for (int i = 0; i < SAMPLES; i++) begin
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(v[11:0]);
    end
  endtask

  task automatic write_all(input int supply, input int series, input bit high_side,
                           input int nominal, input int beta, input int ref_c);
    write_reg(REG_SUPPLY, supply);
    write_reg(REG_SERIES, series);
    write_reg(REG_HIGH, 32'(high_side));
    write_reg(REG_NOMINAL, nominal);
    write_reg(REG_BETA, beta);
    write_reg(REG_REFTEMP, ref_c);
  endtask

  // Mostly realistic calibration, now and then an extreme or a zero write.
  task automatic random_calibration();
    int supply, series, nominal, beta, ref_c;
    supply = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1000, 5000);
    series = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 'hFFFFFF)
                                         : $urandom_range(100, 200000);
    nominal = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 'hFFFFFF)
                                          : $urandom_range(100, 200000);
    beta = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 'h1FFFF)
                                       : $urandom_range(2000, 5000);
    ref_c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 'hFFFF)
                                        : $urandom_range(0, 5000);
    write_all(supply, series, $urandom_range(0, 1), nominal, beta, ref_c);
  endtask

  initial begin
    int supply_now;
    smp_if.valid <= 1'b0;
    smp_if.sample_mv <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: the rails, mid scale and the full-scale sample.
    for (int i = 0; i < SAMPLES; i++) send_sample((i % 2) ? 12'hFFF : 12'h000);
    send_group(0, 0);
    send_group(1650, 0);
    send_group(4095, 0);
    wait_drained();

    // Zero calibration writes are dropped, bad indexes are ignored, and a
    // tiny supply puts every mean at a rail.
    write_reg(REG_NOMINAL, 0);
    write_reg(REG_BETA, 0);
    write_reg(3'd6, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_group(1650, 20);
    wait_drained();
    write_all(10, 10000, 1'b0, 10000, 3950, 2500);
    send_group(12, 2);
    wait_drained();

    // No series resistor, then extreme resistors, beta and reference.
    write_all(5000, 0, 1'b0, 1, 1, -5000);
    send_group(2500, 10);
    wait_drained();
    write_all(5000, 10000000, 1'b1, 1, 1, 15000);
    send_group(100, 5);
    send_group(4900 > 4095 ? 4095 : 4900, 0);
    wait_drained();
    write_all(1000, 'hFFFFFF, 1'b1, 'hFFFFFF, 100000, 'h7FFF);
    send_group(500, 30);
    wait_drained();
    write_all(3300, 1, 1'b0, 10000000, 'h1FFFF, 'h4000);
    send_group(1650, 30);
    wait_drained();

    // Random calibrations with groups spread over the whole divider range.
    for (int phase = 0; phase < 11; phase++) begin
      random_calibration();
      supply_now = $urandom_range(1000, 5000);
      write_reg(REG_SUPPLY, supply_now);
      if (phase == 10) gaps_on = 1'b0;
      for (int g = 0; g < 9; g++) begin
        if ($urandom_range(0, 9) == 0) send_group($urandom_range(0, 4095), 2047);
        else send_group($urandom_range(30, supply_now - 30), $urandom_range(0, 40));
        // Let the pipeline run dry once in a while before sending more.
        if (gaps_on && $urandom_range(0, 7) == 0) begin
          smp_if.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_cnt != 0) @(posedge clk_i);
        end
      end
      if (phase < 10) wait_drained();
    end

    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("ntc_beta_temperature_converter_tb: PASS");
    end else begin
      $display("ntc_beta_temperature_converter_tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
